[rtl/core/bpd_pkg.sv]
// Shared types, constants and lookup functions for the bifid periodic decryptor.
// No dependencies; all rtl/core modules but bpd_stream_if import this package.
`timescale 1ns / 1ps

package bpd_pkg;

    localparam int MAX_PERIOD_DEF = 64;
    localparam int LETTER_W       = 5;
    localparam int KEY_LEN        = 25;
    localparam int KEY_W          = KEY_LEN * LETTER_W;
    localparam int CFG_DATA_W     = 60;
    localparam int CFG_IDX_W      = 2;
    localparam int PERIOD_W       = 7;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LAST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd3;

    typedef struct packed {
        logic [LETTER_W-1:0] cipher_letter;
        logic                message_end;
    } cipher_item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] plain_letter;
        logic                bad_letter;
        logic                block_last;
        logic                message_last;
    } plain_item_t;

    // One classified letter on its way from the front end to the back end.
    typedef struct packed {
        logic                absent;
        logic [LETTER_W-1:0] pos;
        logic                close;
        logic                msg_end;
    } coord_entry_t;

    // Key position of a letter; the lowest position wins on repeated letters.
    // Bit 5 set means the letter is not in the key.
    function automatic logic [5:0] find_letter(input logic [KEY_W-1:0] key,
                                               input logic [LETTER_W-1:0] letter);
        logic [5:0] res;
        res = 6'b100000;
        for (int i = KEY_LEN - 1; i >= 0; i--) begin
            if (key[i*LETTER_W +: LETTER_W] == letter) begin
                res = {1'b0, 5'(i)};
            end
        end
        return res;
    endfunction

    function automatic logic [LETTER_W-1:0] key_at(input logic [KEY_W-1:0] key,
                                                   input logic [4:0] idx);
        logic [LETTER_W-1:0] res;
        res = '0;
        for (int i = 0; i < KEY_LEN; i++) begin
            if (idx == 5'(i)) begin
                res = key[i*LETTER_W +: LETTER_W];
            end
        end
        return res;
    endfunction

    // Row (odd = 0) or column (odd = 1) of a square position 0..24.
    function automatic logic [2:0] coord_of(input logic [4:0] pos, input logic odd);
        logic [2:0] row;
        logic [4:0] rest;
        if (pos >= 5'd20) begin
            row = 3'd4;
        end else if (pos >= 5'd15) begin
            row = 3'd3;
        end else if (pos >= 5'd10) begin
            row = 3'd2;
        end else if (pos >= 5'd5) begin
            row = 3'd1;
        end else begin
            row = 3'd0;
        end
        rest = pos - ({row, 2'b00} + 5'(row));
        return odd ? rest[2:0] : row;
    endfunction

endpackage

[rtl/core/bpd_stream_if.sv]
// Valid/ready stream channel used on both sides of the decryptor.
// The payload type is set per instance from the types in bpd_pkg.
`timescale 1ns / 1ps

interface bpd_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/bifid_periodic_decrypt.sv]
// Bifid periodic decryptor over a 5x5 key square. Depends on bpd_pkg,
// bpd_stream_if, bpd_front, bpd_queue and bpd_back.
// Throughput: one letter a cycle is loaded while the queue has room; one result a cycle
// is emitted while the output is not stalled. A block is emitted only once fully loaded,
// and the back end takes no new letters from the queue while it emits a block.
// Reset clears the control state and sets the key to zeros and the period to 64.
`timescale 1ns / 1ps

module bifid_periodic_decrypt
    import bpd_pkg::*;
#(
    parameter int MAX_PERIOD = MAX_PERIOD_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bpd_stream_if.sink            cipher,
    bpd_stream_if.source          plain
);

    logic [CFG_DATA_W-1:0] key_low_reg;
    logic [CFG_DATA_W-1:0] key_mid_reg;
    logic [LETTER_W-1:0]   key_last_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [KEY_W-1:0]      key;

    coord_entry_t push_data;
    coord_entry_t pop_data;
    logic         push;
    logic         full;
    logic         pop;
    logic         empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_low_reg  <= '0;
            key_mid_reg  <= '0;
            key_last_reg <= '0;
            period_reg   <= PERIOD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_MID:  key_mid_reg  <= cfg_data;
                REG_KEY_LAST: key_last_reg <= cfg_data[LETTER_W-1:0];
                REG_PERIOD:   period_reg   <= cfg_data[PERIOD_W-1:0];
                default:      ;
            endcase
        end
    end

    assign key = {key_last_reg, key_mid_reg, key_low_reg};

    bpd_front #(.MAX_PERIOD(MAX_PERIOD)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cipher (cipher),
        .key    (key),
        .period (period_reg),
        .entry  (push_data),
        .push   (push),
        .full   (full)
    );

    bpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    bpd_back #(.MAX_PERIOD(MAX_PERIOD)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .empty    (empty),
        .pop      (pop),
        .key      (key),
        .plain    (plain)
    );

endmodule

[rtl/core/bpd_front.sv]
// Front end: accepts ciphertext letters, finds their key positions and decides
// where blocks close. Depends on bpd_pkg and bpd_stream_if.
`timescale 1ns / 1ps

module bpd_front
    import bpd_pkg::*;
#(
    parameter int MAX_PERIOD = MAX_PERIOD_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    bpd_stream_if.sink          cipher,
    input  logic [KEY_W-1:0]    key,
    input  logic [PERIOD_W-1:0] period,
    output coord_entry_t        entry,
    output logic                push,
    input  logic                full
);

    localparam int LW = $clog2(MAX_PERIOD + 1);
    localparam logic [PERIOD_W-1:0] MAXP_V = PERIOD_W'(MAX_PERIOD);

    logic [LW-1:0]       fill_reg;
    logic [LW-1:0]       fill_next;
    logic [LW-1:0]       fill_inc;
    logic [PERIOD_W-1:0] eff;
    logic [5:0]          found;
    logic                close;

    assign cipher.ready = !full;
    assign push         = cipher.valid && !full;

    assign fill_inc = fill_reg + LW'(1);
    assign found    = find_letter(key, cipher.payload.cipher_letter);

    always_comb
    begin
        if (period == '0) begin
            eff = PERIOD_W'(1);
        end else if (period > MAXP_V) begin
            eff = MAXP_V;
        end else begin
            eff = period;
        end
    end

    // A lowered period closes the block as soon as the count reaches or passes it.
    assign close = cipher.payload.message_end || (PERIOD_W'(fill_inc) >= eff);

    always_comb
    begin
        entry.absent  = found[5];
        entry.pos     = found[4:0];
        entry.close   = close;
        entry.msg_end = cipher.payload.message_end;
    end

    assign fill_next = push ? (close ? '0 : fill_inc) : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

[rtl/core/bpd_queue.sv]
// Short FIFO of classified letters between the front end and the back end.
// Depends on bpd_pkg for the entry type and the depth.
`timescale 1ns / 1ps

module bpd_queue
    import bpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  coord_entry_t push_data,
    output logic         full,
    input  logic         pop,
    output coord_entry_t pop_data,
    output logic         empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    coord_entry_t    slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

[rtl/core/bpd_back.sv]
// Back end: stores one block of coordinates and, once the block closes, emits
// one plaintext letter per stored letter. Depends on bpd_pkg and bpd_stream_if.
`timescale 1ns / 1ps

module bpd_back
    import bpd_pkg::*;
#(
    parameter int MAX_PERIOD = MAX_PERIOD_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  coord_entry_t     pop_data,
    input  logic             empty,
    output logic             pop,
    input  logic [KEY_W-1:0] key,
    bpd_stream_if.source     plain
);

    localparam int AW = $clog2(MAX_PERIOD);
    localparam int LW = AW + 1;

    logic [5:0]    coord_mem [MAX_PERIOD];

    logic [AW-1:0] wptr_reg;
    logic          emit_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] j_reg;
    logic          end_reg;

    logic          s1_valid_reg;
    logic          s1_p0_reg;
    logic          s1_p1_reg;
    logic          s1_blast_reg;
    logic          s1_mlast_reg;
    logic [5:0]    rd0_reg;
    logic [5:0]    rd1_reg;

    logic          out_valid_reg;
    plain_item_t   out_reg;

    logic          s1_move;
    logic          advance;
    logic          issue;
    logic          last;
    logic [LW-1:0] sum;
    logic [AW-1:0] addr0;
    logic [AW-1:0] addr1;
    logic          bad;
    logic [2:0]    row;
    logic [2:0]    col;
    logic [4:0]    idx;
    plain_item_t   result;

    assign s1_move = !out_valid_reg || plain.ready;
    assign advance = !s1_valid_reg || s1_move;
    assign issue   = emit_reg && advance;
    assign pop     = !emit_reg && !empty;

    // Result j takes its row from sequence entry j and its column from entry j+len.
    assign sum   = j_reg + len_reg;
    assign addr0 = j_reg[LW-1:1];
    assign addr1 = sum[LW-1:1];
    assign last  = (j_reg == len_reg - LW'(1));

    always_ff @(posedge clk)
    begin
        if (pop) begin
            coord_mem[wptr_reg] <= {pop_data.absent, pop_data.pos};
        end
        if (issue) begin
            rd0_reg <= coord_mem[addr0];
            rd1_reg <= coord_mem[addr1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            emit_reg <= 1'b0;
            len_reg  <= '0;
            j_reg    <= '0;
            end_reg  <= 1'b0;
        end else begin
            if (pop) begin
                if (pop_data.close) begin
                    wptr_reg <= '0;
                    emit_reg <= 1'b1;
                    len_reg  <= LW'(wptr_reg) + LW'(1);
                    j_reg    <= '0;
                    end_reg  <= pop_data.msg_end;
                end else begin
                    wptr_reg <= wptr_reg + AW'(1);
                end
            end else if (issue) begin
                if (last) begin
                    emit_reg <= 1'b0;
                end else begin
                    j_reg <= j_reg + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue) begin
            s1_p0_reg    <= j_reg[0];
            s1_p1_reg    <= sum[0];
            s1_blast_reg <= last;
            s1_mlast_reg <= last && end_reg;
        end
    end

    always_comb
    begin
        bad = rd0_reg[5] || rd1_reg[5];
        row = coord_of(rd0_reg[4:0], s1_p0_reg);
        col = coord_of(rd1_reg[4:0], s1_p1_reg);
        idx = {row, 2'b00} + 5'(row) + 5'(col);
        result.plain_letter = bad ? '0 : key_at(key, idx);
        result.bad_letter   = bad;
        result.block_last   = s1_blast_reg;
        result.message_last = s1_mlast_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg) begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                s1_valid_reg <= issue;
            end
            if (s1_move) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign plain.valid   = out_valid_reg;
    assign plain.payload = out_reg;

    // A held read stage must keep its memory data while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> ($stable(rd0_reg) && $stable(rd1_reg)))
        else $error("read data changed while the read stage was stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (plain.valid && plain.payload.message_last) |-> plain.payload.block_last)
        else $error("message end emitted away from a block end");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg |-> ((len_reg != '0) && (j_reg < len_reg)))
        else $error("emit counter outside the closed block");

endmodule
